// ===== design/rvg_pkg.sv =====
// rvg_pkg: payload types, register codes and fixed widths for the radial vignetting gain block
// no dependencies; used by rvg_channel and radial_vignetting_gain

package rvg_pkg;

    // input transfer: whole-pixel coordinate
    typedef struct packed {
        logic [11:0] pixel_y;
        logic [11:0] pixel_x;
    } in_t;

    // output transfer: three unsigned Q4.16 gains
    typedef struct packed {
        logic [19:0] gain_blue;
        logic [19:0] gain_green;
        logic [19:0] gain_red;
    } out_t;

    // per-channel settings handed to one channel datapath
    typedef struct packed {
        logic [15:0] center_y;
        logic [15:0] center_x;
        logic [59:0] coeffs;
        logic [5:0]  norm_shift;
    } chan_cfg_t;

    // register indexes (byte address / 8)
    localparam logic [2:0] REG_CENTER_RED   = 3'd0;
    localparam logic [2:0] REG_CENTER_GREEN = 3'd1;
    localparam logic [2:0] REG_CENTER_BLUE  = 3'd2;
    localparam logic [2:0] REG_COEFFS_RED   = 3'd3;
    localparam logic [2:0] REG_COEFFS_GREEN = 3'd4;
    localparam logic [2:0] REG_COEFFS_BLUE  = 3'd5;
    localparam logic [2:0] REG_NORM_SHIFT   = 3'd6;

    localparam logic [5:0] NORM_SHIFT_RESET = 6'd24;

    // fixed datapath widths
    localparam int COEF_W = 20;   // signed Q4.16 coefficient
    localparam int U_W    = 18;   // unsigned Q2.16 normalized radius
    localparam int ACC_W  = 24;   // signed Q8.16 Horner accumulator
    localparam int GAIN_W = 20;   // unsigned Q4.16 gain

endpackage

// ===== design/rvg_channel.sv =====
// rvg_channel: pipelined datapath for one color channel (radius, normalize, Horner)
// depends on rvg_pkg; instantiated three times by radial_vignetting_gain

module rvg_channel
    import rvg_pkg::*;
#(
    parameter int DEG = 3
) (
    input  logic              aclk,
    input  logic              adv,
    input  in_t               pix,
    input  chan_cfg_t         cfg,
    output logic [GAIN_W-1:0] gain
);

    localparam int PROD_W = ACC_W + U_W + 1;   // acc times zero-extended u
    localparam int RND_W  = PROD_W - 15;       // rounded product, one spare bit
    localparam int SUM_W  = RND_W + 1;         // rounded product plus coefficient

    // stage 1: signed offsets from the center, 1/16 pixel units
    logic signed [17:0] dx_reg, dy_reg;
    logic signed [17:0] dx_next, dy_next;

    assign dx_next = $signed({2'b00, cfg.center_x}) - $signed({2'b00, pix.pixel_x, 4'b0000});
    assign dy_next = $signed({2'b00, cfg.center_y}) - $signed({2'b00, pix.pixel_y, 4'b0000});

    always_ff @(posedge aclk) begin
        if (adv) begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
    end

    // stage 2: squares, each below 2^32
    logic signed [35:0] sqx_full, sqy_full;
    logic [31:0]        sqx_reg, sqy_reg;

    assign sqx_full = dx_reg * dx_reg;
    assign sqy_full = dy_reg * dy_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            sqx_reg <= sqx_full[31:0];
            sqy_reg <= sqy_full[31:0];
        end
    end

    // stage 3: squared radius, shift and saturate to Q2.16, load top coefficient
    logic [32:0]              rsq, rsq_sh;
    logic [U_W-1:0]           u0_next;
    logic [U_W-1:0]           u_reg   [DEG];
    logic signed [ACC_W-1:0]  acc_reg [DEG];
    logic [COEF_W-1:0]        k_top;

    assign rsq     = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign rsq_sh  = rsq >> cfg.norm_shift;
    assign u0_next = (rsq_sh[32:U_W] != '0) ? {U_W{1'b1}} : rsq_sh[U_W-1:0];
    assign k_top   = cfg.coeffs[COEF_W*(DEG-1) +: COEF_W];

    always_ff @(posedge aclk) begin
        if (adv) begin
            u_reg[0]   <= u0_next;
            acc_reg[0] <= {{(ACC_W-COEF_W){k_top[COEF_W-1]}}, k_top};
        end
    end

    // Horner steps: a multiply stage then a round/add/saturate stage each
    logic signed [PROD_W-1:0] prod_reg  [DEG];
    logic [U_W-1:0]           u_mid_reg [DEG];
    logic [GAIN_W-1:0]        gain_reg;

    for (genvar i = 0; i < DEG; i++) begin : g_step
        logic signed [PROD_W:0]  rnd_sum;
        logic signed [RND_W-1:0] rnd;

        always_ff @(posedge aclk) begin
            if (adv) begin
                prod_reg[i]  <= acc_reg[i] * $signed({1'b0, u_reg[i]});
                u_mid_reg[i] <= u_reg[i];
            end
        end

        // floor((p + 0.5 lsb) / 2^16)
        assign rnd_sum = {prod_reg[i][PROD_W-1], prod_reg[i]} + (PROD_W+1)'(32768);
        assign rnd     = rnd_sum[PROD_W:16];

        if (i < DEG-1) begin : g_mid
            logic [COEF_W-1:0]       k;
            logic signed [SUM_W-1:0] t;
            logic signed [ACC_W-1:0] acc_next;

            assign k = cfg.coeffs[COEF_W*(DEG-2-i) +: COEF_W];
            assign t = {rnd[RND_W-1], rnd} + {{(SUM_W-COEF_W){k[COEF_W-1]}}, k};

            // clamp to signed Q8.16
            always_comb begin
                if (t > SUM_W'(2**(ACC_W-1) - 1)) begin
                    acc_next = {1'b0, {(ACC_W-1){1'b1}}};
                end else if (t < -$signed(SUM_W'(2**(ACC_W-1)))) begin
                    acc_next = {1'b1, {(ACC_W-1){1'b0}}};
                end else begin
                    acc_next = t[ACC_W-1:0];
                end
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    acc_reg[i+1] <= acc_next;
                    u_reg[i+1]   <= u_mid_reg[i];
                end
            end
        end else begin : g_last
            logic signed [SUM_W-1:0] g;
            logic [GAIN_W-1:0]       gain_next;

            assign g = {rnd[RND_W-1], rnd} + SUM_W'(65536);

            // clamp to unsigned Q4.16
            always_comb begin
                if (g < 0) begin
                    gain_next = '0;
                end else if (g > SUM_W'(2**GAIN_W - 1)) begin
                    gain_next = {GAIN_W{1'b1}};
                end else begin
                    gain_next = g[GAIN_W-1:0];
                end
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    gain_reg <= gain_next;
                end
            end
        end
    end

    assign gain = gain_reg;

endmodule

// ===== design/radial_vignetting_gain.sv =====
// radial_vignetting_gain: top level with register file, valid chain and three channel datapaths
// depends on rvg_pkg and rvg_channel
//
//  channel | ports                                     | carries
//  --------+-------------------------------------------+---------------------------------
//  input   | s_valid, s_ready, s_data                  | pixel_x, pixel_y
//  output  | m_valid, m_ready, m_data                  | gain_red, gain_green, gain_blue
//  config  | psel, penable, pwrite, paddr, pwdata, ... | seven registers at 8*index
//
// one coordinate per cycle while the output is not stalled; one multiply
// stage and one round/saturate stage per Horner step after three radius stages
// the whole pipeline, output register included, holds while m_ready is low
// and m_valid is high; s_ready follows that enable
// reset clears the valid chain and the registers (norm_shift to 24)

module radial_vignetting_gain
    import rvg_pkg::*;
#(
    parameter int POLY_DEGREE = 3
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,

    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int DEG = (POLY_DEGREE < 1) ? 1 : ((POLY_DEGREE > 3) ? 3 : POLY_DEGREE);
    localparam int LAT = 3 + 2*DEG;

    // register file
    logic [31:0] center_reg [3];
    logic [59:0] coeff_reg  [3];
    logic [5:0]  norm_shift_reg;
    logic [2:0]  reg_idx;
    logic        wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < 3; c++) begin
                center_reg[c] <= '0;
                coeff_reg[c]  <= '0;
            end
            norm_shift_reg <= NORM_SHIFT_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_CENTER_RED:   center_reg[0]  <= pwdata[31:0];
                REG_CENTER_GREEN: center_reg[1]  <= pwdata[31:0];
                REG_CENTER_BLUE:  center_reg[2]  <= pwdata[31:0];
                REG_COEFFS_RED:   coeff_reg[0]   <= pwdata[59:0];
                REG_COEFFS_GREEN: coeff_reg[1]   <= pwdata[59:0];
                REG_COEFFS_BLUE:  coeff_reg[2]   <= pwdata[59:0];
                REG_NORM_SHIFT:   norm_shift_reg <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (reg_idx)
            REG_CENTER_RED:   prdata = {32'd0, center_reg[0]};
            REG_CENTER_GREEN: prdata = {32'd0, center_reg[1]};
            REG_CENTER_BLUE:  prdata = {32'd0, center_reg[2]};
            REG_COEFFS_RED:   prdata = {4'd0, coeff_reg[0]};
            REG_COEFFS_GREEN: prdata = {4'd0, coeff_reg[1]};
            REG_COEFFS_BLUE:  prdata = {4'd0, coeff_reg[2]};
            REG_NORM_SHIFT:   prdata = {58'd0, norm_shift_reg};
            default:          prdata = '0;
        endcase
    end

    // valid chain; every stage moves together
    logic           adv;
    logic [LAT-1:0] valid_reg, valid_next;

    assign adv        = !valid_reg[LAT-1] || m_ready;
    assign s_ready    = adv;
    assign valid_next = {valid_reg[LAT-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= valid_next;
        end
    end

    assign m_valid = valid_reg[LAT-1];

    // per-channel datapaths
    chan_cfg_t         ch_cfg  [3];
    logic [GAIN_W-1:0] ch_gain [3];

    for (genvar c = 0; c < 3; c++) begin : g_chan
        assign ch_cfg[c] = '{center_y:   center_reg[c][31:16],
                             center_x:   center_reg[c][15:0],
                             coeffs:     coeff_reg[c],
                             norm_shift: norm_shift_reg};

        rvg_channel #(
            .DEG (DEG)
        ) u_chan (
            .aclk (aclk),
            .adv  (adv),
            .pix  (s_data),
            .cfg  (ch_cfg[c]),
            .gain (ch_gain[c])
        );
    end

    assign m_data = '{gain_blue: ch_gain[2], gain_green: ch_gain[1], gain_red: ch_gain[0]};

    // checks
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && (valid_reg == '0))
        else $error("valid chain not empty after reset");

    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(valid_reg))
        else $error("pipeline moved during output stall");

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |=> (valid_reg[0] == $past(s_valid)))
        else $error("input transfer not captured in first stage");

    a_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> (valid_reg[LAT-1:1] == $past(valid_reg[LAT-2:0])))
        else $error("valid chain did not advance");

endmodule
